FILE: hdl/sar_pkg.sv
// shared types, command codes and constants for the scroll address register unit
`timescale 1ns / 1ps
`default_nettype none

package sar_pkg;

    localparam logic [3:0] CMD_CTRL_WR   = 4'd0;
    localparam logic [3:0] CMD_MASK_WR   = 4'd1;
    localparam logic [3:0] CMD_SCROLL_WR = 4'd2;
    localparam logic [3:0] CMD_ADDR_WR   = 4'd3;
    localparam logic [3:0] CMD_DATA      = 4'd4;
    localparam logic [3:0] CMD_STATUS_RD = 4'd5;
    localparam logic [3:0] CMD_INC_X     = 4'd6;
    localparam logic [3:0] CMD_INC_Y     = 4'd7;
    localparam logic [3:0] CMD_COPY_X    = 4'd8;
    localparam logic [3:0] CMD_COPY_Y    = 4'd9;

    localparam logic [4:0] COARSE_Y_WRAP_NT = 5'd29;
    localparam logic [4:0] COARSE_Y_LAST    = 5'd31;
    localparam logic [1:0] FETCH_BASE_HI    = 2'b10;
    localparam logic [3:0] ATTR_BASE_MID    = 4'b1111;

    typedef struct packed {
        logic [3:0] cmd;
        logic [7:0] data_byte;
    } sar_in_t;

    typedef struct packed {
        logic [14:0] current_addr;
        logic [14:0] temp_addr;
        logic [2:0]  fine_x_scroll;
        logic        second_write;
        logic [13:0] tile_fetch_addr;
        logic [13:0] attr_fetch_addr;
        logic [2:0]  attr_shift;
    } sar_out_t;

    typedef struct packed {
        logic [14:0] cur_addr;
        logic [14:0] tmp_addr;
        logic [2:0]  fine_x;
        logic        toggle;
        logic        step_32;
        logic        render_on;
    } sar_state_t;

endpackage

`default_nettype wire

FILE: hdl/scroll_address_register_unit.sv
// top level of the scroll address register unit: state, result register and handshake
// latency: a result appears in the cycle after its command transaction is taken
// throughput: one command per cycle, sustained while the result side keeps up
// the result register frees itself in the same cycle it is taken, so no bubble is added
// reset: asynchronous active low, clears all address and mode state and the result valid
`timescale 1ns / 1ps
`default_nettype none

module scroll_address_register_unit (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cmd_valid,
    output logic               cmd_ready,
    input  wire sar_pkg::sar_in_t  cmd_data,
    output logic               res_valid,
    input  wire                res_ready,
    output sar_pkg::sar_out_t  res_data
);
    import sar_pkg::*;

    sar_state_t state_reg;
    sar_state_t state_next;
    sar_out_t   res_reg;
    sar_out_t   res_next;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       cmd_fire;
    logic [14:0] v;

    sar_update u_update (
        .state      (state_reg),
        .cmd_in     (cmd_data),
        .state_next (state_next)
    );

    assign cmd_ready = !res_valid_reg || res_ready;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign v         = state_next.cur_addr;

    always_comb
    begin
        res_next.current_addr    = v;
        res_next.temp_addr       = state_next.tmp_addr;
        res_next.fine_x_scroll   = state_next.fine_x;
        res_next.second_write    = state_next.toggle;
        res_next.tile_fetch_addr = {FETCH_BASE_HI, v[11:0]};
        res_next.attr_fetch_addr = {FETCH_BASE_HI, v[11:10], ATTR_BASE_MID, v[9:7], v[4:2]};
        res_next.attr_shift      = {v[6], v[1], 1'b0};
    end

    assign res_valid_next = cmd_fire ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cmd_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

`default_nettype wire

FILE: hdl/sar_update.sv
// next-state logic for one command applied to the scroll and address registers
`timescale 1ns / 1ps
`default_nettype none

module sar_update (
    input  wire sar_pkg::sar_state_t state,
    input  wire sar_pkg::sar_in_t    cmd_in,
    output sar_pkg::sar_state_t      state_next
);
    import sar_pkg::*;

    logic [7:0]  d;
    logic [14:0] v;
    logic [14:0] t;
    logic [14:0] v_step;

    assign d = cmd_in.data_byte;
    assign v = state.cur_addr;
    assign t = state.tmp_addr;
    assign v_step = state.step_32 ? 15'd32 : 15'd1;

    always_comb
    begin
        state_next = state;
        case (cmd_in.cmd)
            CMD_CTRL_WR:
            begin
                state_next.tmp_addr[11:10] = d[1:0];
                state_next.step_32         = d[2];
            end
            CMD_MASK_WR:
            begin
                state_next.render_on = d[3] | d[4];
            end
            CMD_SCROLL_WR:
            begin
                if (!state.toggle)
                begin
                    state_next.fine_x        = d[2:0];
                    state_next.tmp_addr[4:0] = d[7:3];
                end
                else
                begin
                    state_next.tmp_addr[14:12] = d[2:0];
                    state_next.tmp_addr[9:5]   = d[7:3];
                end
                state_next.toggle = ~state.toggle;
            end
            CMD_ADDR_WR:
            begin
                if (!state.toggle)
                begin
                    state_next.tmp_addr[14]   = 1'b0;
                    state_next.tmp_addr[13:8] = d[5:0];
                end
                else
                begin
                    state_next.tmp_addr[7:0] = d;
                    state_next.cur_addr      = {t[14:8], d};
                end
                state_next.toggle = ~state.toggle;
            end
            CMD_DATA:
            begin
                state_next.cur_addr = v + v_step;
            end
            CMD_STATUS_RD:
            begin
                state_next.toggle = 1'b0;
            end
            CMD_INC_X:
            begin
                if (state.render_on)
                begin
                    if (v[4:0] == 5'h1f)
                    begin
                        state_next.cur_addr[4:0] = 5'd0;
                        state_next.cur_addr[10]  = ~v[10];
                    end
                    else
                    begin
                        state_next.cur_addr[4:0] = v[4:0] + 5'd1;
                    end
                end
            end
            CMD_INC_Y:
            begin
                if (state.render_on)
                begin
                    if (v[14:12] != 3'd7)
                    begin
                        state_next.cur_addr[14:12] = v[14:12] + 3'd1;
                    end
                    else
                    begin
                        state_next.cur_addr[14:12] = 3'd0;
                        if (v[9:5] == COARSE_Y_WRAP_NT)
                        begin
                            state_next.cur_addr[9:5] = 5'd0;
                            state_next.cur_addr[11]  = ~v[11];
                        end
                        else if (v[9:5] == COARSE_Y_LAST)
                        begin
                            state_next.cur_addr[9:5] = 5'd0;
                        end
                        else
                        begin
                            state_next.cur_addr[9:5] = v[9:5] + 5'd1;
                        end
                    end
                end
            end
            CMD_COPY_X:
            begin
                if (state.render_on)
                begin
                    state_next.cur_addr[10]  = t[10];
                    state_next.cur_addr[4:0] = t[4:0];
                end
            end
            CMD_COPY_Y:
            begin
                if (state.render_on)
                begin
                    state_next.cur_addr[14:11] = t[14:11];
                    state_next.cur_addr[9:5]   = t[9:5];
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/sar_checker.sv
// port-level assertions for the scroll address register unit and their bind
`timescale 1ns / 1ps
`default_nettype none

module sar_checker (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    cmd_valid,
    input wire                    cmd_ready,
    input wire sar_pkg::sar_in_t  cmd_data,
    input wire                    res_valid,
    input wire                    res_ready,
    input wire sar_pkg::sar_out_t res_data
);
    import sar_pkg::*;

    // a taken command always yields a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> res_valid)
        else $error("no result after command transaction");

    // a stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // status read clears the write toggle
    a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_data.cmd == CMD_STATUS_RD
        |=> !res_data.second_write)
        else $error("toggle not cleared by status read");

    // tile fetch tracks the current address
    a_tile_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.tile_fetch_addr[13:12] == FETCH_BASE_HI
            && res_data.tile_fetch_addr[11:0] == res_data.current_addr[11:0])
        else $error("tile fetch address mismatch");

    // attribute fetch tracks the current address and the quadrant shift keeps a zero low bit
    a_attr_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.attr_fetch_addr[11:10] == res_data.current_addr[11:10]
            && res_data.attr_fetch_addr[5:3] == res_data.current_addr[9:7]
            && res_data.attr_fetch_addr[2:0] == res_data.current_addr[4:2]
            && res_data.attr_shift[0] == 1'b0)
        else $error("attribute fetch address mismatch");

endmodule

bind scroll_address_register_unit sar_checker u_sar_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

`default_nettype wire

FILE: tb/scroll_address_register_unit_test.sv
// self-checking testbench for the scroll address register unit with a built-in predictor
`timescale 1ns / 1ps

module scroll_address_register_unit_test;

    import sar_pkg::*;

    localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
    localparam int         STALL_LIMIT   = 3000;
    localparam int         LONG_HOLD     = 400;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    sar_in_t  cmd_data = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    sar_out_t res_data;

    sar_in_t  pending_commands[$];
    sar_out_t expected_reports[$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int errors = 0;

    // predicted register state
    logic [14:0] v_addr = '0;
    logic [14:0] t_addr = '0;
    logic [2:0]  fine_x_q = '0;
    logic        toggle_q = 1'b0;
    logic        step_32_q = 1'b0;
    logic        render_q = 1'b0;

    scroll_address_register_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic advance_scroll_regs(input sar_in_t c, output sar_out_t r);
        logic [7:0] d;
        logic [4:0] cy;
        d = c.data_byte;
        case (c.cmd)
            CMD_CTRL_WR:
            begin
                t_addr[11:10] = d[1:0];
                step_32_q = d[2];
            end
            CMD_MASK_WR:
                render_q = d[3] | d[4];
            CMD_SCROLL_WR:
                if (!toggle_q)
                begin
                    fine_x_q = d[2:0];
                    t_addr[4:0] = d[7:3];
                    toggle_q = 1'b1;
                end
                else
                begin
                    t_addr[14:12] = d[2:0];
                    t_addr[9:5] = d[7:3];
                    toggle_q = 1'b0;
                end
            CMD_ADDR_WR:
                if (!toggle_q)
                begin
                    t_addr[13:8] = d[5:0];
                    t_addr[14] = 1'b0;
                    toggle_q = 1'b1;
                end
                else
                begin
                    t_addr[7:0] = d;
                    v_addr = t_addr;
                    toggle_q = 1'b0;
                end
            CMD_DATA:
                v_addr = v_addr + (step_32_q ? 15'd32 : 15'd1);
            CMD_STATUS_RD:
                toggle_q = 1'b0;
            CMD_INC_X:
                if (render_q)
                begin
                    if (v_addr[4:0] == 5'd31)
                    begin
                        v_addr[4:0] = 5'd0;
                        v_addr[10] = ~v_addr[10];
                    end
                    else
                        v_addr[4:0] = v_addr[4:0] + 5'd1;
                end
            CMD_INC_Y:
                if (render_q)
                begin
                    if (v_addr[14:12] != 3'd7)
                        v_addr[14:12] = v_addr[14:12] + 3'd1;
                    else
                    begin
                        v_addr[14:12] = 3'd0;
                        cy = v_addr[9:5];
                        if (cy == COARSE_Y_WRAP_NT)
                        begin
                            v_addr[9:5] = 5'd0;
                            v_addr[11] = ~v_addr[11];
                        end
                        else if (cy == COARSE_Y_LAST)
                            v_addr[9:5] = 5'd0;
                        else
                            v_addr[9:5] = cy + 5'd1;
                    end
                end
            CMD_COPY_X:
                if (render_q)
                begin
                    v_addr[10] = t_addr[10];
                    v_addr[4:0] = t_addr[4:0];
                end
            CMD_COPY_Y:
                if (render_q)
                begin
                    v_addr[14:11] = t_addr[14:11];
                    v_addr[9:5] = t_addr[9:5];
                end
            default:
                ;
        endcase
        r.current_addr = v_addr;
        r.temp_addr = t_addr;
        r.fine_x_scroll = fine_x_q;
        r.second_write = toggle_q;
        r.tile_fetch_addr = {2'b10, v_addr[11:0]};
        r.attr_fetch_addr = 14'h23C0 | {2'b00, v_addr[11:10], 4'b0000, v_addr[9:7], v_addr[4:2]};
        r.attr_shift = {v_addr[6], v_addr[1], 1'b0};
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // driver
    always @(posedge clk)
    begin : drive_commands
        sar_out_t predicted;
        if (!rst_n)
            cmd_valid <= 1'b0;
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                advance_scroll_regs(cmd_data, predicted);
                expected_reports.push_back(predicted);
            end
            if (cmd_valid && !cmd_ready)
                ;
            else if (pending_commands.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                cmd_valid <= 1'b1;
                cmd_data <= pending_commands.pop_front();
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin : check_results
        sar_out_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected transaction, expected none, actual %h",
                             $time, res_data);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("current_addr", want.current_addr, res_data.current_addr);
                    compare_field("temp_addr", want.temp_addr, res_data.temp_addr);
                    compare_field("fine_x_scroll", want.fine_x_scroll, res_data.fine_x_scroll);
                    compare_field("second_write", want.second_write, res_data.second_write);
                    compare_field("tile_fetch_addr", want.tile_fetch_addr,
                                  res_data.tile_fetch_addr);
                    compare_field("attr_fetch_addr", want.attr_fetch_addr,
                                  res_data.attr_fetch_addr);
                    compare_field("attr_shift", want.attr_shift, res_data.attr_shift);
                end
            end
            if (hold_ack != hold_req)
            begin
                hold_ack = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                stall_cycles <= 0;
            else if (pending_commands.size() > 0 || cmd_valid || expected_reports.size() > 0)
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic push_cmd(input logic [3:0] c, input logic [7:0] d);
        sar_in_t item;
        item.cmd = c;
        item.data_byte = d;
        pending_commands.push_back(item);
    endtask

    task automatic push_random_cmd();
        int r;
        logic [3:0] c;
        r = $urandom_range(0, 99);
        if (r < 6)
            c = CMD_CTRL_WR;
        else if (r < 10)
            c = CMD_MASK_WR;
        else if (r < 20)
            c = CMD_SCROLL_WR;
        else if (r < 30)
            c = CMD_ADDR_WR;
        else if (r < 38)
            c = CMD_DATA;
        else if (r < 43)
            c = CMD_STATUS_RD;
        else if (r < 60)
            c = CMD_INC_X;
        else if (r < 75)
            c = CMD_INC_Y;
        else if (r < 83)
            c = CMD_COPY_X;
        else if (r < 91)
            c = CMD_COPY_Y;
        else
            c = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        push_cmd(c, 8'($urandom_range(0, 255)));
        // keep register writes in pairs most of the time
        if ((c == CMD_SCROLL_WR || c == CMD_ADDR_WR) && $urandom_range(0, 9) < 8)
            push_cmd(c, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(input int n_items, input int s_idle, input int r_stall,
                             input bit long_hold);
        @(negedge clk);
        sender_idle_pct = s_idle;
        receiver_stall_pct = r_stall;
        while (pending_commands.size() < n_items)
            push_random_cmd();
        if (long_hold)
            hold_req++;
        while (pending_commands.size() > 0 || cmd_valid || expected_reports.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // rendering off: the render commands must leave everything alone
        push_cmd(CMD_SCROLL_WR, 8'hFF);
        push_cmd(CMD_SCROLL_WR, 8'hFF);
        push_cmd(CMD_CTRL_WR, 8'hFB);
        push_cmd(CMD_COPY_X, 8'h00);
        push_cmd(CMD_COPY_Y, 8'hFF);
        push_cmd(CMD_INC_X, 8'h00);
        push_cmd(CMD_INC_Y, 8'h00);
        // rendering on: copies, coarse X wrap, Y wrap at 31
        push_cmd(CMD_MASK_WR, 8'h08);
        push_cmd(CMD_COPY_X, 8'h00);
        push_cmd(CMD_COPY_Y, 8'h00);
        push_cmd(CMD_INC_X, 8'h00);
        push_cmd(CMD_INC_Y, 8'h00);
        push_cmd(CMD_DATA, 8'h00);
        push_cmd(CMD_CTRL_WR, 8'h04);
        push_cmd(CMD_DATA, 8'h00);
        // status read in the middle of a scroll pair, then Y wrap at 29
        push_cmd(CMD_SCROLL_WR, 8'h07);
        push_cmd(CMD_STATUS_RD, 8'h00);
        push_cmd(CMD_SCROLL_WR, 8'hEF);
        push_cmd(CMD_SCROLL_WR, 8'hEF);
        push_cmd(CMD_COPY_Y, 8'h00);
        push_cmd(CMD_INC_Y, 8'h00);
        push_cmd(CMD_ADDR_WR, 8'hFF);
        push_cmd(CMD_ADDR_WR, 8'hFF);
        push_cmd(CMD_MASK_WR, 8'h10);
        push_cmd(CMD_UNUSED_HI, 8'hFF);
        push_cmd(CMD_MASK_WR, 8'hE7);
        push_cmd(CMD_UNUSED_LO, 8'h00);
        run_phase(0, 0, 0, 1'b0);

        push_cmd(CMD_MASK_WR, 8'h18);
        run_phase(180, 0, 0, 1'b1);
        run_phase(170, 57, 0, 1'b0);
        run_phase(170, 0, 57, 1'b0);
        run_phase(170, 25, 25, 1'b0);

        repeat (10) @(posedge clk);
        if (errors == 0 && expected_reports.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: scroll_address_register_unit.f
hdl/sar_pkg.sv
hdl/sar_update.sv
hdl/scroll_address_register_unit.sv
hdl/sar_checker.sv
tb/scroll_address_register_unit_test.sv
